### design/assert_macros.svh
// Assertion macros for the RTL; included by the core top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define STC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define STC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/stcpu_pkg.sv
// Shared types, constants and helper functions of the toy CPU core.
package stcpu_pkg;

    localparam int MEM_AW    = 11;
    localparam int MEM_BYTES = 1 << MEM_AW;
    localparam int REG_COUNT = 16;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int DATA_W    = 16;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_EXEC  = 2'd1,
        ACT_RDREG = 2'd2,
        ACT_RDMEM = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_AND = 4'd2,
        OP_ORR = 4'd3,
        OP_EOR = 4'd4,
        OP_LSL = 4'd5,
        OP_LSR = 4'd6,
        OP_ASR = 4'd7,
        OP_LDR = 4'd8,
        OP_STR = 4'd9,
        OP_CMP = 4'd10,
        OP_MOV = 4'd11,
        OP_B   = 4'd12,
        OP_BEQ = 4'd13,
        OP_END = 4'd14,
        OP_NOP = 4'd15
    } t_opcode;

    typedef struct packed {
        t_opcode           op;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } t_alu_req;

    typedef logic [MEM_AW-1:0] t_maddr;

    function automatic t_maddr mem_wrap(input logic [DATA_W-1:0] a);
        return a[MEM_AW-1:0];
    endfunction

    function automatic logic pc_out_of_range(input logic [DATA_W-1:0] pc);
        return |pc[DATA_W-1:MEM_AW];
    endfunction

    function automatic logic [DATA_W-1:0] sext8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

    function automatic logic [DATA_W-1:0] sext12(input logic [11:0] v);
        return {{4{v[11]}}, v};
    endfunction

endpackage

### design/sixteen_bit_toy_cpu_core.sv
// Top level of the 16-bit toy CPU core: sequencer, state and shared units.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+--------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_action, i_address, i_data_byte,
//          |             |             | i_register_index
//  out     | o_out_valid | i_out_ready | o_read_data, o_program_counter, o_halted,
//          |             |             | o_zero_flag_out
//
// After reset the core sweeps byte memory and registers to zero, not ready
// meanwhile. A write goes straight to done, a read captures its data first,
// and execute fetches, reads registers, runs, moves a second byte for LDR or
// STR and updates pc, or goes straight to done when halted. Single-port
// memories set these steps. One word in flight at a time; a finished word waits
// in the output register while the next is accepted; a full one holds the core in done.
`include "assert_macros.svh"

module sixteen_bit_toy_cpu_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [10:0] i_address,
    input  logic [7:0]  i_data_byte,
    input  logic [3:0]  i_register_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_read_data,
    output logic [15:0] o_program_counter,
    output logic        o_halted,
    output logic        o_zero_flag_out
);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_CAPT   = 13'b0000000000100,
        S_FETCH1 = 13'b0000000001000,
        S_FETCH2 = 13'b0000000010000,
        S_RDA    = 13'b0000000100000,
        S_RDB    = 13'b0000001000000,
        S_EXEC   = 13'b0000010000000,
        S_LOAD1  = 13'b0000100000000,
        S_LOAD2  = 13'b0001000000000,
        S_STORE2 = 13'b0010000000000,
        S_PCUPD  = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    logic [stcpu_pkg::MEM_AW-1:0] r_clr_cnt, n_clr_cnt;
    stcpu_pkg::t_action           r_act, n_act;
    logic [15:0]                  r_ir, n_ir;
    logic [15:0]                  r_va, n_va;
    logic [15:0]                  r_vb, n_vb;
    logic [15:0]                  r_res, n_res;
    logic [7:0]                   r_hi, n_hi;
    stcpu_pkg::t_maddr            r_maddr, n_maddr;
    logic [15:0]                  r_pc, n_pc;
    logic                         r_zf, n_zf;
    logic                         r_halt, n_halt;

    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_rd, n_out_rd;
    logic [15:0] r_out_pc, n_out_pc;
    logic        r_out_halt, n_out_halt;
    logic        r_out_zf, n_out_zf;

    logic                          in_accept;
    stcpu_pkg::t_action            in_act;
    stcpu_pkg::t_maddr             in_maddr;
    stcpu_pkg::t_opcode            op;
    logic [stcpu_pkg::REG_AW-1:0]  fld_d;
    logic                          taken;
    logic                          out_free;

    logic                          mem_we;
    stcpu_pkg::t_maddr             mem_addr;
    logic [7:0]                    mem_wdata;
    logic [7:0]                    mem_rdata;

    logic                          reg_we;
    logic [stcpu_pkg::REG_AW-1:0]  reg_addr;
    logic [15:0]                   reg_wdata;
    logic [15:0]                   reg_rdata;

    stcpu_pkg::t_alu_req           alu_req;
    logic [15:0]                   alu_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_act     = stcpu_pkg::t_action'(i_action);
    assign in_maddr   = stcpu_pkg::mem_wrap(16'(i_address));
    assign op         = stcpu_pkg::t_opcode'(r_ir[15:12]);
    assign fld_d      = r_ir[11:8];
    assign taken      = (op == stcpu_pkg::OP_B) || ((op == stcpu_pkg::OP_BEQ) && r_zf);
    assign out_free   = !r_out_valid || i_out_ready;

    stcpu_ram #(
        .WIDTH (8),
        .DEPTH (stcpu_pkg::MEM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    stcpu_ram #(
        .WIDTH (stcpu_pkg::DATA_W),
        .DEPTH (stcpu_pkg::REG_COUNT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_addr  (reg_addr),
        .i_wdata (reg_wdata),
        .o_rdata (reg_rdata)
    );

    stcpu_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // the pc update step reuses the ALU adder
    always_comb begin
        if (r_state == S_PCUPD) begin
            alu_req.op = stcpu_pkg::OP_ADD;
            alu_req.x  = r_pc;
            alu_req.y  = taken ? stcpu_pkg::sext12(r_ir[11:0]) : 16'd2;
        end else begin
            alu_req.op = op;
            alu_req.x  = r_va;
            alu_req.y  = r_vb;
        end
    end

    // byte memory port
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = stcpu_pkg::mem_wrap(r_pc);
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr_cnt;
            end
            S_IDLE: begin
                if (in_accept && (in_act == stcpu_pkg::ACT_WRITE)) begin
                    mem_we    = 1'b1;
                    mem_addr  = in_maddr;
                    mem_wdata = i_data_byte;
                end else if (in_accept && (in_act == stcpu_pkg::ACT_RDMEM)) begin
                    mem_addr = in_maddr;
                end
            end
            S_FETCH1: mem_addr = stcpu_pkg::mem_wrap(r_pc) + 1'b1;
            S_EXEC: begin
                mem_addr = stcpu_pkg::mem_wrap(r_va);
                if (op == stcpu_pkg::OP_STR) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_vb[15:8];
                end
            end
            S_LOAD1: mem_addr = r_maddr + 1'b1;
            S_STORE2: begin
                mem_we    = 1'b1;
                mem_addr  = r_maddr + 1'b1;
                mem_wdata = r_vb[7:0];
            end
            default: ;
        endcase
    end

    // register file port
    always_comb begin
        reg_we    = 1'b0;
        reg_addr  = i_register_index;
        reg_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                reg_we   = 1'b1;
                reg_addr = r_clr_cnt[stcpu_pkg::REG_AW-1:0];
            end
            // Ra comes straight off the second fetch byte
            S_FETCH2: reg_addr = mem_rdata[7:4];
            S_RDA: begin
                if (op == stcpu_pkg::OP_STR || op == stcpu_pkg::OP_CMP) begin
                    reg_addr = fld_d;
                end else begin
                    reg_addr = r_ir[3:0];
                end
            end
            S_EXEC: begin
                reg_addr = fld_d;
                if (op inside {[stcpu_pkg::OP_ADD:stcpu_pkg::OP_ASR]}) begin
                    reg_we    = 1'b1;
                    reg_wdata = alu_res;
                end else if (op == stcpu_pkg::OP_MOV) begin
                    reg_we    = 1'b1;
                    reg_wdata = stcpu_pkg::sext8(r_ir[7:0]);
                end
            end
            S_LOAD2: begin
                reg_we    = 1'b1;
                reg_addr  = fld_d;
                reg_wdata = {r_hi, mem_rdata};
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_act       = r_act;
        n_ir        = r_ir;
        n_va        = r_va;
        n_vb        = r_vb;
        n_res       = r_res;
        n_hi        = r_hi;
        n_maddr     = r_maddr;
        n_pc        = r_pc;
        n_zf        = r_zf;
        n_halt      = r_halt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_rd    = r_out_rd;
        n_out_pc    = r_out_pc;
        n_out_halt  = r_out_halt;
        n_out_zf    = r_out_zf;
        case (r_state)
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == stcpu_pkg::MEM_AW'(stcpu_pkg::MEM_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_act = in_act;
                    n_res = '0;
                    case (in_act)
                        stcpu_pkg::ACT_WRITE: n_state = S_DONE;
                        stcpu_pkg::ACT_EXEC: begin
                            if (r_halt) begin
                                n_state = S_DONE;
                            end else if (stcpu_pkg::pc_out_of_range(r_pc)) begin
                                n_halt  = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_FETCH1;
                            end
                        end
                        default: n_state = S_CAPT;
                    endcase
                end
            end
            S_CAPT: begin
                n_res   = (r_act == stcpu_pkg::ACT_RDREG) ? reg_rdata : {8'h00, mem_rdata};
                n_state = S_DONE;
            end
            S_FETCH1: begin
                n_ir[15:8] = mem_rdata;
                n_state    = S_FETCH2;
            end
            S_FETCH2: begin
                n_ir[7:0] = mem_rdata;
                n_state   = S_RDA;
            end
            S_RDA: begin
                n_va    = reg_rdata;
                n_state = S_RDB;
            end
            S_RDB: begin
                n_vb    = reg_rdata;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_maddr = stcpu_pkg::mem_wrap(r_va);
                case (op)
                    stcpu_pkg::OP_LDR: n_state = S_LOAD1;
                    stcpu_pkg::OP_STR: n_state = S_STORE2;
                    stcpu_pkg::OP_CMP: begin
                        n_zf    = (r_vb == r_va);
                        n_state = S_PCUPD;
                    end
                    default: n_state = S_PCUPD;
                endcase
            end
            S_LOAD1: begin
                n_hi    = mem_rdata;
                n_state = S_LOAD2;
            end
            S_LOAD2:  n_state = S_PCUPD;
            S_STORE2: n_state = S_PCUPD;
            S_PCUPD: begin
                // END keeps pc on itself
                if (op == stcpu_pkg::OP_END) begin
                    n_halt = 1'b1;
                end else begin
                    n_pc = alu_res;
                    if (stcpu_pkg::pc_out_of_range(alu_res)) begin
                        n_halt = 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_rd    = r_res;
                    n_out_pc    = r_pc;
                    n_out_halt  = r_halt;
                    n_out_zf    = r_zf;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_pc        <= '0;
            r_zf        <= 1'b0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_pc        <= n_pc;
            r_zf        <= n_zf;
            r_halt      <= n_halt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_ir       <= n_ir;
        r_va       <= n_va;
        r_vb       <= n_vb;
        r_res      <= n_res;
        r_hi       <= n_hi;
        r_maddr    <= n_maddr;
        r_out_rd   <= n_out_rd;
        r_out_pc   <= n_out_pc;
        r_out_halt <= n_out_halt;
        r_out_zf   <= n_out_zf;
    end

    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_out_rd;
    assign o_program_counter = r_out_pc;
    assign o_halted          = r_out_halt;
    assign o_zero_flag_out   = r_out_zf;

    `STC_ASSERT_IMP(a_pc_range_halts, stcpu_pkg::pc_out_of_range(r_pc), r_halt)
    `STC_ASSERT_NXT(a_halt_sticks, r_halt, r_halt)
    `STC_ASSERT_NXT(a_done_delivers, (r_state == S_DONE) && out_free, r_out_valid && (r_state == S_IDLE))

endmodule

### design/stcpu_ram.sv
// Generic single-port RAM with registered read data.
module stcpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/stcpu_alu.sv
// Shared 16-bit ALU: add, subtract, logic ops and shifts.
module stcpu_alu (
    input  stcpu_pkg::t_alu_req          i_req,
    output logic [stcpu_pkg::DATA_W-1:0] o_res
);

    logic       big_shift;
    logic [3:0] amt;
    logic [stcpu_pkg::DATA_W-1:0] fill;

    assign big_shift = |i_req.y[stcpu_pkg::DATA_W-1:4];
    assign amt       = i_req.y[3:0];
    assign fill      = {stcpu_pkg::DATA_W{i_req.x[stcpu_pkg::DATA_W-1]}};

    always_comb begin
        case (i_req.op)
            stcpu_pkg::OP_ADD: o_res = i_req.x + i_req.y;
            stcpu_pkg::OP_SUB: o_res = i_req.x - i_req.y;
            stcpu_pkg::OP_AND: o_res = i_req.x & i_req.y;
            stcpu_pkg::OP_ORR: o_res = i_req.x | i_req.y;
            stcpu_pkg::OP_EOR: o_res = i_req.x ^ i_req.y;
            stcpu_pkg::OP_LSL: o_res = big_shift ? '0 : (i_req.x << amt);
            stcpu_pkg::OP_LSR: o_res = big_shift ? '0 : (i_req.x >> amt);
            stcpu_pkg::OP_ASR: o_res = big_shift ? fill
                                     : stcpu_pkg::DATA_W'($signed(i_req.x) >>> amt);
            default:           o_res = '0;
        endcase
    end

endmodule
